FILE: rtl/revc_pkg.sv
package revc_pkg;

  localparam int VALUE_W     = 16;
  localparam int MULT_W      = 8;
  localparam int DIFF_W      = 8;
  localparam int LED_COUNT_W = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PHASE   = 2'd0,
    CMD_PROCESS = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VALUE_MIN       = 3'd0,
    REG_VALUE_MAX       = 3'd1,
    REG_STEP_MULTIPLIER = 3'd2,
    REG_FAST_MULTIPLIER = 3'd3,
    REG_WRAP_ENABLE     = 3'd4,
    REG_LEDS_ENABLE     = 3'd5,
    REG_WIDE_MODE       = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DIFF_W-1:0] diff;
    logic                     pressed;
    logic                     fast;
    logic [VALUE_W-1:0]       load_value;
  } action_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_min;
    logic [VALUE_W-1:0] value_max;
    logic [MULT_W-1:0]  step_multiplier;
    logic [MULT_W-1:0]  fast_multiplier;
    logic               wrap_enable;
    logic               leds_enable;
    logic               wide_mode;
  } cfg_t;

endpackage

FILE: rtl/revc_queue.sv
module revc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  revc_pkg::action_t push_data,
  output logic              full,
  input  logic              pop,
  output revc_pkg::action_t pop_data,
  output logic              not_empty
);
  import revc_pkg::*;

  localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  action_t           entries [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign full      = (count == CountW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/revc_front.sv
module revc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic                          phase_a,
  input  logic                          phase_b,
  input  logic                          button_level,
  input  logic [revc_pkg::VALUE_W-1:0]  load_value,
  input  logic                          queue_full,
  output logic                          push,
  output revc_pkg::action_t             push_data
);
  import revc_pkg::*;

  localparam logic [7:0] FastIdleLimit = 8'd2;
  localparam logic [7:0] IdleMax       = 8'hFF;

  logic [1:0]        last_phase, last_phase_next;
  logic [7:0]        step_acc, step_acc_next;
  logic [7:0]        idle_count, idle_count_next;
  logic              button_held, button_held_next;
  logic [1:0]        now_phase;
  logic [1:0]        delta;
  logic              accept;
  logic              pressed;
  logic signed [5:0] detents;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    now_phase        = {phase_a, phase_a ^ phase_b};
    delta            = last_phase - now_phase;
    detents          = $signed(step_acc[7:2]);
    pressed          = !button_level && !button_held;
    last_phase_next  = last_phase;
    step_acc_next    = step_acc;
    idle_count_next  = idle_count;
    button_held_next = button_held;
    push             = 1'b0;
    push_data.op         = OP_STEP;
    push_data.diff       = {{2{detents[5]}}, detents};
    push_data.pressed    = pressed;
    push_data.fast       = (idle_count < FastIdleLimit);
    push_data.load_value = load_value;
    if (accept) begin
      unique case (cmd_t'(cmd))
        CMD_PHASE: begin
          if (delta[0]) begin
            last_phase_next = now_phase;
            step_acc_next   = step_acc + (delta[1] ? 8'h01 : 8'hFF);
          end
        end
        CMD_PROCESS: begin
          step_acc_next    = {6'd0, step_acc[1:0]};
          button_held_next = !button_level;
          if ((detents == 6'sd0) && !pressed) begin
            if (idle_count != IdleMax) begin
              idle_count_next = idle_count + 8'd1;
            end
          end else begin
            push            = 1'b1;
            idle_count_next = '0;
          end
        end
        CMD_LOAD: begin
          push         = 1'b1;
          push_data.op = OP_LOAD;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase  <= '0;
      step_acc    <= '0;
      idle_count  <= '0;
      button_held <= 1'b0;
    end else begin
      last_phase  <= last_phase_next;
      step_acc    <= step_acc_next;
      idle_count  <= idle_count_next;
      button_held <= button_held_next;
    end
  end

endmodule

FILE: rtl/revc_back.sv
module revc_back #(
  parameter int LED_SEGMENTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  revc_pkg::cfg_t                   cfg,
  input  logic                             queue_valid,
  input  revc_pkg::action_t                queue_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [revc_pkg::VALUE_W-1:0]     value,
  output logic [revc_pkg::LED_COUNT_W-1:0] led_count
);
  import revc_pkg::*;

  localparam int QuotW = $clog2(LED_SEGMENTS) + 1;
  localparam int NumW  = VALUE_W + QuotW;
  localparam int StepW = $clog2(QuotW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_PRESS,
    S_LED,
    S_DIV,
    S_OUT
  } state_t;

  state_t                   state;
  action_t                  act;
  logic signed [DIFF_W-1:0] diff;
  logic [VALUE_W-1:0]       t;
  logic [VALUE_W-1:0]       current_value;
  logic [VALUE_W-1:0]       value_q;
  logic [NumW-1:0]          num;
  logic [NumW-1:0]          dsh;
  logic [QuotW-1:0]         quot;
  logic [StepW-1:0]         steps;
  logic                     out_valid_q;

  logic [VALUE_W-1:0]       stored;
  logic [MULT_W-1:0]        mult_sel;
  logic [15:0]              product;
  logic signed [17:0]       sum;
  logic                     dpos;
  logic                     dneg;
  logic [VALUE_W-1:0]       clamped;
  logic [VALUE_W-1:0]       half;
  logic [VALUE_W-1:0]       pressed_t;
  logic [VALUE_W-1:0]       div_raw;
  logic [VALUE_W-1:0]       divisor;
  logic                     ge;

  assign pop       = (state == S_IDLE) && queue_valid;
  assign out_valid = out_valid_q;
  assign value     = value_q;
  assign led_count = LED_COUNT_W'(quot);

  always_comb begin
    stored   = cfg.wide_mode ? current_value : {8'h00, current_value[7:0]};
    mult_sel = (state == S_MUL2) ? cfg.fast_multiplier : cfg.step_multiplier;
    product  = {8'h00, diff} * {8'h00, mult_sel};
    sum      = $signed({2'b00, stored}) + $signed({{10{diff[7]}}, diff});
    dpos     = !diff[7] && (diff != '0);
    dneg     = diff[7];
    if (dpos && (sum > $signed({2'b00, cfg.value_max}))) begin
      clamped = cfg.wrap_enable ? cfg.value_min : cfg.value_max;
    end else if (dneg && (sum < $signed({2'b00, cfg.value_min}))) begin
      clamped = cfg.wrap_enable ? cfg.value_max : cfg.value_min;
    end else begin
      clamped = sum[VALUE_W-1:0];
    end
    half = cfg.value_max >> 1;
    if (t < half) begin
      pressed_t = half;
    end else if (t < cfg.value_max) begin
      pressed_t = cfg.value_max;
    end else begin
      pressed_t = cfg.value_min;
    end
    div_raw = cfg.value_max - cfg.value_min;
    divisor = (div_raw == '0) ? VALUE_W'(1) : div_raw;
    ge      = (num >= dsh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid_q   <= 1'b0;
      current_value <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (queue_valid) begin
            act  <= queue_data;
            diff <= queue_data.diff;
            if (queue_data.op == OP_LOAD) begin
              t     <= cfg.wide_mode ? queue_data.load_value
                                     : {8'h00, queue_data.load_value[7:0]};
              state <= S_LED;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          diff  <= product[7:0];
          state <= act.fast ? S_MUL2 : S_SUM;
        end
        S_MUL2: begin
          diff  <= product[7:0];
          state <= S_SUM;
        end
        S_SUM: begin
          t     <= clamped;
          state <= S_PRESS;
        end
        S_PRESS: begin
          if (act.pressed) begin
            t <= pressed_t;
          end
          state <= S_LED;
        end
        S_LED: begin
          current_value <= cfg.wide_mode ? t : {8'h00, t[7:0]};
          value_q       <= cfg.wide_mode ? t : {8'h00, t[7:0]};
          num           <= NumW'(t) * NumW'(LED_SEGMENTS);
          dsh           <= NumW'(divisor) << (QuotW - 1);
          steps         <= StepW'(QuotW);
          quot          <= '0;
          if (!cfg.leds_enable) begin
            out_valid_q <= 1'b1;
            state       <= S_OUT;
          end else if (t >= divisor) begin
            quot        <= QuotW'(LED_SEGMENTS);
            out_valid_q <= 1'b1;
            state       <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            num <= num - dsh;
          end
          quot  <= QuotW'({quot, ge});
          dsh   <= dsh >> 1;
          steps <= steps - 1'b1;
          if (steps == StepW'(1)) begin
            out_valid_q <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_q <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_valid_in_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> (state == S_OUT))
    else $error("result shown outside the output state");

  a_led_count_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> (quot <= QuotW'(LED_SEGMENTS)))
    else $error("LED count above segment count");

  a_div_steps_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (steps != '0))
    else $error("division ran past its last step");
`endif

endmodule

FILE: rtl/rotary_encoder_value_controller.sv
// Quadrature encoder and push button front end that steers a bounded value.
// Input channel (in_valid/in_ready): each item carries cmd with the phase
// levels, the button level or a load value. A phase sample updates the step
// count only; a process item turns whole detents and new presses into a value
// step; a load item sets the value directly. Steps and loads produce one
// result on the output channel (out_valid/out_ready): the stored value and the
// number of lit bar segments. Phase samples, idle process items and the
// unused command produce nothing.
// The input side takes one item per cycle while the two-entry action queue
// has room. The back end works on one action at a time: a step passes through
// the multiply (again with the fast multiplier for fast steps), sum and press
// states and a load skips them; then the bar division, when LEDs are enabled
// and the value is below value_max - value_min, makes one quotient bit per cycle.
// The result stays in its output register until out_ready; the queue keeps
// taking items meanwhile and in_ready drops only when it is full.
// Synchronous reset clears the decoder, button and idle state, the value and
// all configuration to its defaults; no result is pending after reset.
// Configuration is written through cfg_we/cfg_index/cfg_data.
module rotary_encoder_value_controller #(
  parameter int LED_SEGMENTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic                             phase_a,
  input  logic                             phase_b,
  input  logic                             button_level,
  input  logic [revc_pkg::VALUE_W-1:0]     load_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [revc_pkg::VALUE_W-1:0]     value,
  output logic [revc_pkg::LED_COUNT_W-1:0] led_count,
  input  logic                             cfg_we,
  input  logic [revc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [revc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import revc_pkg::*;

  cfg_t    cfg;
  logic    push;
  action_t push_data;
  logic    queue_full;
  logic    pop;
  action_t pop_data;
  logic    queue_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_min       <= VALUE_W'(0);
      cfg.value_max       <= VALUE_W'(255);
      cfg.step_multiplier <= MULT_W'(1);
      cfg.fast_multiplier <= MULT_W'(1);
      cfg.wrap_enable     <= 1'b0;
      cfg.leds_enable     <= 1'b0;
      cfg.wide_mode       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VALUE_MIN:       cfg.value_min       <= cfg_data[VALUE_W-1:0];
        REG_VALUE_MAX:       cfg.value_max       <= cfg_data[VALUE_W-1:0];
        REG_STEP_MULTIPLIER: cfg.step_multiplier <= cfg_data[MULT_W-1:0];
        REG_FAST_MULTIPLIER: cfg.fast_multiplier <= cfg_data[MULT_W-1:0];
        REG_WRAP_ENABLE:     cfg.wrap_enable     <= cfg_data[0];
        REG_LEDS_ENABLE:     cfg.leds_enable     <= cfg_data[0];
        REG_WIDE_MODE:       cfg.wide_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  revc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .phase_a      (phase_a),
    .phase_b      (phase_b),
    .button_level (button_level),
    .load_value   (load_value),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  revc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_valid)
  );

  revc_back #(
    .LED_SEGMENTS (LED_SEGMENTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_valid (queue_valid),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .led_count   (led_count)
  );

endmodule
